// ===== src/stwm_pkg.sv =====
// stwm_pkg: types, codes and descriptor helpers for the stage-1 table walk map unit.
// No dependencies; imported by stwm_front, stwm_back and the top level.
`timescale 1ns / 1ps
package stwm_pkg;

   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W = 9;
   localparam int VA_W = 27;
   localparam int PAGE_W = 36;
   localparam int DESC_W = 64;

   localparam logic [2:0] MODE_MAP = 3'd0;
   localparam logic [2:0] MODE_MAP_VEC = 3'd1;
   localparam logic [2:0] MODE_LOOKUP = 3'd2;
   localparam logic [2:0] MODE_PROTECT = 3'd3;
   localparam logic [2:0] MODE_UNMAP = 3'd4;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_POOL_EMPTY = 2'd1;
   localparam logic [1:0] ST_NOT_MAPPED = 2'd2;

   localparam logic [1:0] CSR_TABLE_BASE = 2'd0;
   localparam logic [1:0] CSR_ATTR_INDEX = 2'd1;

   localparam logic [63:0] ADDR_FIELD = 64'h0000_FFFF_FFFF_F000;

   typedef struct packed {
      logic [2:0]        mode;
      logic [VA_W-1:0]   va_page;
      logic [PAGE_W-1:0] ipa_page;
      logic [2:0]        prot;
   } item_type;

   typedef struct packed {
      logic [PAGE_W-1:0] table_base;
      logic [2:0]        attr_index;
   } cfg_type;

   function automatic logic [63:0] common_attrs(input logic [2:0] attr);
      common_attrs = 64'h0000_0000_0000_0700 | {59'd0, attr, 2'b00};
   endfunction

   function automatic logic [63:0] prot_attrs(input logic [2:0] attr, input logic [2:0] prot);
      logic [63:0] a;
      a = common_attrs(attr);
      a[53] = 1'b1;
      a[6] = |prot;
      a[7] = ~prot[1];
      a[54] = ~prot[2];
      prot_attrs = a;
   endfunction

endpackage

// ===== src/stwm_front.sv =====
// stwm_front: accepts items and holds them in a two-entry queue for the walk engine.
// Depends on stwm_pkg.
`timescale 1ns / 1ps
module stwm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stwm_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output stwm_pkg::item_type head_item
);
   import stwm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/stwm_back.sv =====
// stwm_back: walk engine with the table memory, pool counter and result registers.
// Depends on stwm_pkg.
`timescale 1ns / 1ps
module stwm_back #(
   parameter int TABLE_PAGES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  stwm_pkg::cfg_type  cfg,
   input  logic               item_avail,
   input  stwm_pkg::item_type head_item,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_descriptor,
   output logic [35:0]        rsp_out_ipa_page
);
   import stwm_pkg::*;

   localparam int TW = $clog2(TABLE_PAGES);
   localparam int UW = $clog2(TABLE_PAGES + 1);
   localparam int AW = TW + IDX_W;
   localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [UW-1:0] POOL_SIZE = UW'(TABLE_PAGES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_L1 = 4'd1;
   localparam logic [3:0] S_L2 = 4'd2;
   localparam logic [3:0] S_L3 = 4'd3;
   localparam logic [3:0] S_DEC = 4'd4;
   localparam logic [3:0] S_WT1 = 4'd5;
   localparam logic [3:0] S_WT2 = 4'd6;
   localparam logic [3:0] S_WLF = 4'd7;

   logic [63:0] mem [DEPTH];
   logic [63:0] rdata_ff;
   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] wa;
   logic [63:0]   wd;

   logic [3:0]    state_ff, state_in;
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [UW-1:0] used_ff, used_in;
   item_type      item_ff, item_in;
   logic          h2_ff, h2_in, h3_ff, h3_in;
   logic [TW-1:0] t2_ff, t2_in, t3_ff, t3_in;
   logic [63:0]   leaf_ff, leaf_in;
   logic [63:0]   desc_ff, desc_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [63:0]   rd_ff, rd_in;
   logic [35:0]   ri_ff, ri_in;

   logic [PAGE_W-1:0] rel;
   logic              hit;
   logic [UW-1:0]     free_cnt;
   logic [1:0]        need;
   logic              have;
   logic [35:0]       old_ipa;

   assign clearing = clr_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_descriptor = rd_ff;
   assign rsp_out_ipa_page = ri_ff;

   function automatic logic [63:0] table_desc(input logic [PAGE_W-1:0] base,
                                              input logic [UW-1:0] t);
      logic [PAGE_W-1:0] p;
      p = base + PAGE_W'(t);
      table_desc = {16'd0, p, 12'h003};
   endfunction

   // follow(): pointer is valid and names a table already taken
   always_comb begin
      rel = rdata_ff[47:12] - cfg.table_base;
      hit = rdata_ff[0] && (rel < PAGE_W'(used_ff));
      free_cnt = POOL_SIZE - used_ff;
      need = h2_ff ? (h3_ff ? 2'd0 : 2'd1) : 2'd2;
      have = h2_ff && h3_ff && leaf_ff[0];
      old_ipa = have ? leaf_ff[47:12] : 36'd0;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      used_in = used_ff;
      item_in = item_ff;
      h2_in = h2_ff;
      h3_in = h3_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      leaf_in = leaf_ff;
      desc_in = desc_ff;
      rv_in = 1'b0;
      rs_in = rs_ff;
      rd_in = rd_ff;
      ri_in = ri_ff;
      pop = 1'b0;
      rd_addr = {{TW{1'b0}}, item_ff.va_page[26:18]};
      we = 1'b0;
      wa = {t3_ff, item_ff.va_page[8:0]};
      wd = 64'd0;

      if (clr_ff) begin
         we = 1'b1;
         wa = clr_cnt_ff;
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == LAST_ADDR) begin
            clr_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rd_addr = {{TW{1'b0}}, head_item.va_page[26:18]};
               if (item_avail) begin
                  pop = 1'b1;
                  item_in = head_item;
                  state_in = S_L1;
               end
            end
            S_L1: begin
               h2_in = hit;
               h3_in = 1'b0;
               leaf_in = 64'd0;
               t2_in = rel[TW-1:0];
               rd_addr = {rel[TW-1:0], item_ff.va_page[17:9]};
               state_in = hit ? S_L2 : S_DEC;
            end
            S_L2: begin
               h3_in = hit;
               t3_in = rel[TW-1:0];
               rd_addr = {rel[TW-1:0], item_ff.va_page[8:0]};
               state_in = hit ? S_L3 : S_DEC;
            end
            S_L3: begin
               leaf_in = rdata_ff;
               state_in = S_DEC;
            end
            S_DEC: begin
               ri_in = old_ipa;
               rd_in = 64'd0;
               rs_in = ST_DONE;
               state_in = S_IDLE;
               case (item_ff.mode)
                  MODE_MAP, MODE_MAP_VEC: begin
                     if (item_ff.mode == MODE_MAP) begin
                        desc_in = {16'd0, item_ff.ipa_page, 12'd0}
                                  | prot_attrs(cfg.attr_index, item_ff.prot) | 64'd3;
                     end else begin
                        desc_in = {16'd0, item_ff.ipa_page, 12'd0}
                                  | common_attrs(cfg.attr_index) | (64'd1 << 54) | 64'd3;
                     end
                     if (free_cnt < UW'(need)) begin
                        rs_in = ST_POOL_EMPTY;
                        rv_in = 1'b1;
                     end else if (!h2_ff) begin
                        state_in = S_WT1;
                     end else if (!h3_ff) begin
                        state_in = S_WT2;
                     end else begin
                        state_in = S_WLF;
                     end
                  end
                  MODE_LOOKUP, MODE_PROTECT, MODE_UNMAP: begin
                     rv_in = 1'b1;
                     if (!have) begin
                        rs_in = ST_NOT_MAPPED;
                     end else if (item_ff.mode == MODE_LOOKUP) begin
                        rd_in = leaf_ff;
                     end else if (item_ff.mode == MODE_PROTECT) begin
                        we = 1'b1;
                        wd = (leaf_ff & ADDR_FIELD)
                             | prot_attrs(cfg.attr_index, item_ff.prot) | 64'd3;
                        rd_in = wd;
                     end else begin
                        we = 1'b1;
                     end
                  end
                  default: begin
                     rv_in = 1'b1;
                  end
               endcase
            end
            S_WT1: begin
               we = 1'b1;
               wa = {{TW{1'b0}}, item_ff.va_page[26:18]};
               wd = table_desc(cfg.table_base, used_ff);
               t2_in = used_ff[TW-1:0];
               used_in = used_ff + UW'(1);
               state_in = S_WT2;
            end
            S_WT2: begin
               we = 1'b1;
               wa = {t2_ff, item_ff.va_page[17:9]};
               wd = table_desc(cfg.table_base, used_ff);
               t3_in = used_ff[TW-1:0];
               used_in = used_ff + UW'(1);
               state_in = S_WLF;
            end
            S_WLF: begin
               we = 1'b1;
               wd = desc_ff;
               rd_in = desc_ff;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         used_ff <= UW'(1);
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         used_ff <= used_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      h2_ff <= h2_in;
      h3_ff <= h3_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      leaf_ff <= leaf_in;
      desc_ff <= desc_in;
      rs_ff <= rs_in;
      rd_ff <= rd_in;
      ri_ff <= ri_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[rd_addr];
   end

endmodule

// ===== src/stage1_table_walk_map_unit.sv =====
// stage1_table_walk_map_unit: top level; config registers, item queue and walk engine.
// Depends on stwm_pkg, stwm_front and stwm_back.
`timescale 1ns / 1ps
//  channel  | ports                                         | handshake
//  request  | req_mode, req_va_page, req_ipa_page, req_prot | start & !busy
//  response | rsp_status, rsp_descriptor, rsp_out_ipa_page  | rsp_valid, one cycle
//  csr      | csr_index, csr_data                           | csr_valid & csr_ready
// In the walk engine an item passes through the pop state, one state per table
// level read up to the first miss and a decide state; a map with room in the pool
// then adds one write state per new table plus the leaf write. The result appears
// on rsp_* the cycle after the last step. Two items can wait in the queue.
// After reset a sweep zeroes all TABLE_PAGES*512 entries of the table memory; busy
// is high throughout. The receiver cannot stall; csr_ready is always high.
module stage1_table_walk_map_unit #(
   parameter int TABLE_PAGES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [26:0] req_va_page,
   input  logic [35:0] req_ipa_page,
   input  logic [2:0]  req_prot,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_descriptor,
   output logic [35:0] rsp_out_ipa_page,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [35:0] csr_data
);
   import stwm_pkg::*;

   cfg_type  cfg_ff;
   item_type push_item;
   item_type head_item;
   logic     push, pop, full, not_empty, clearing;

   assign csr_ready = 1'b1;
   assign busy = full || clearing;
   assign push = start && !busy;
   assign push_item = '{mode: req_mode, va_page: req_va_page,
                        ipa_page: req_ipa_page, prot: req_prot};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_base <= 36'h4_0000;
         cfg_ff.attr_index <= 3'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_BASE: cfg_ff.table_base <= csr_data;
            CSR_ATTR_INDEX: cfg_ff.attr_index <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   stwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   stwm_back #(.TABLE_PAGES(TABLE_PAGES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .item_avail       (not_empty),
      .head_item        (head_item),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_descriptor   (rsp_descriptor),
      .rsp_out_ipa_page (rsp_out_ipa_page)
   );

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid) else $error("response during memory clear");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy) else $error("not busy after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_POOL_EMPTY
                     || rsp_status == ST_NOT_MAPPED)) else $error("bad status");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");

endmodule
